### rtl/rag_pkg.sv
// shared types and constants for the rational arithmetic reduce block
package rag_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_CHK,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

### rtl/rag_gcd.sv
// binary gcd unit, one shift or subtract step per cycle
module rag_gcd #(
    parameter int MW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_x,
    input  logic [MW-1:0] i_y,
    output logic          o_done,
    output logic [MW-1:0] o_g
);

    localparam int KW = $clog2(MW + 1);

    logic          r_busy;
    logic [MW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic [KW-1:0] r_k;
    logic          w_end;

    assign w_end  = (r_x == '0) || (r_y == '0);
    assign o_done = r_busy && w_end;
    assign o_g    = MW'((r_x | r_y) << r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_busy && !w_end) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
    end

endmodule

### rtl/rag_cell.sv
// one restoring division cell: one quotient bit for the numerator and denominator lanes
module rag_cell #(
    parameter int MW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [MW-1:0] i_div,
    input  logic [MW-1:0] i_rem_n,
    input  logic [MW-1:0] i_dvd_n,
    input  logic [MW-1:0] i_quo_n,
    input  logic [MW-1:0] i_rem_d,
    input  logic [MW-1:0] i_dvd_d,
    input  logic [MW-1:0] i_quo_d,
    output logic          o_valid,
    output logic [MW-1:0] o_div,
    output logic [MW-1:0] o_rem_n,
    output logic [MW-1:0] o_dvd_n,
    output logic [MW-1:0] o_quo_n,
    output logic [MW-1:0] o_rem_d,
    output logic [MW-1:0] o_dvd_d,
    output logic [MW-1:0] o_quo_d
);

    logic [MW:0] w_sh_n;
    logic [MW:0] w_sh_d;
    logic        w_ge_n;
    logic        w_ge_d;

    assign w_sh_n = {i_rem_n, i_dvd_n[MW-1]};
    assign w_sh_d = {i_rem_d, i_dvd_d[MW-1]};
    assign w_ge_n = w_sh_n >= {1'b0, i_div};
    assign w_ge_d = w_sh_d >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_div   <= i_div;
        o_rem_n <= MW'(w_ge_n ? w_sh_n - {1'b0, i_div} : w_sh_n);
        o_rem_d <= MW'(w_ge_d ? w_sh_d - {1'b0, i_div} : w_sh_d);
        o_dvd_n <= i_dvd_n << 1;
        o_dvd_d <= i_dvd_d << 1;
        o_quo_n <= {i_quo_n[MW-2:0], w_ge_n};
        o_quo_d <= {i_quo_d[MW-2:0], w_ge_d};
    end

endmodule

### rtl/rational_arith_gcd_reduce.sv
// top level: fraction add/sub/mul/div with gcd reduction
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | i_valid / o_ready   | i_opcode, i_a_num, i_a_den, i_b_num, i_b_den
//  out     | o_valid / i_ready   | o_result_num, o_result_den, o_status
//
// one item at a time: after the input transfer, the products, cross sums and checks,
// then the binary gcd (one step a cycle), then the launch register and the chain
// of 2*IN_WIDTH division cells, then the output register
// a zero denominator, or a zero b numerator in a division, skips gcd and division and gives zeros with status set
// reset (synchronous, active low) empties the pipe and the output register
// a new item is taken while a finished result still waits for its transfer
module rational_arith_gcd_reduce #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [IN_WIDTH-1:0]        i_a_num,
    input  logic [IN_WIDTH-1:0]        i_a_den,
    input  logic [IN_WIDTH-1:0]        i_b_num,
    input  logic [IN_WIDTH-1:0]        i_b_den,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rag_pkg::NUM_W-1:0]  o_result_num,
    output logic [rag_pkg::DEN_W-1:0]  o_result_den,
    output logic                       o_status
);

    localparam int W  = IN_WIDTH;
    localparam int MW = 2 * IN_WIDTH;   // magnitude width of the cross products

    rag_pkg::t_state r_state, n_state;

    // captured operands
    rag_pkg::t_op          r_op;
    logic signed [W-1:0]   r_an, r_ad, r_bn, r_bd;
    // products and cross sums
    logic signed [MW-1:0]  r_p1, r_p2, r_rd;
    logic signed [MW:0]    r_rn;
    logic                  r_err;
    logic [MW-1:0]         r_g;
    logic [MW-1:0]         r_qn, r_qd;

    // output register
    logic                        r_out_valid;
    logic [rag_pkg::NUM_W-1:0]   r_out_num;
    logic [rag_pkg::DEN_W-1:0]   r_out_den;
    logic                        r_out_status;

    logic          w_accept;
    logic          w_gcd_start;
    logic          w_gcd_done;
    logic [MW-1:0] w_gcd_g;
    logic [MW-1:0] w_mag_n, w_mag_d;
    logic          w_load;
    logic          w_out_free;

    // chain of division cells, one quotient bit per cell, launched once the gcd is known
    logic          w_chain_valid [0:MW];
    logic [MW-1:0] w_chain_div   [0:MW];
    logic [MW-1:0] w_rem_n [0:MW];
    logic [MW-1:0] w_dvd_n [0:MW];
    logic [MW-1:0] w_quo_n [0:MW];
    logic [MW-1:0] w_rem_d [0:MW];
    logic [MW-1:0] w_dvd_d [0:MW];
    logic [MW-1:0] w_quo_d [0:MW];

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // magnitudes of the cross products
    assign w_mag_n = MW'(r_rn[MW]   ? -r_rn : r_rn);
    assign w_mag_d = MW'(r_rd[MW-1] ? -r_rd : r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rag_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_gcd_start = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            rag_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = rag_pkg::S_MUL;
            end
            rag_pkg::S_MUL: n_state = rag_pkg::S_SUM;
            rag_pkg::S_SUM: n_state = rag_pkg::S_CHK;
            rag_pkg::S_CHK: begin
                if (r_err) begin
                    n_state = rag_pkg::S_DONE;
                end else begin
                    w_gcd_start = 1'b1;
                    n_state     = rag_pkg::S_GCD;
                end
            end
            rag_pkg::S_GCD: if (w_gcd_done) n_state = rag_pkg::S_DIV;
            rag_pkg::S_DIV: if (w_chain_valid[MW]) n_state = rag_pkg::S_DONE;
            rag_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = rag_pkg::S_IDLE;
                end
            end
            default: n_state = rag_pkg::S_IDLE;
        endcase
    end

    // operand capture, products and cross sums
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= rag_pkg::t_op'(i_opcode);
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (r_state == rag_pkg::S_MUL) begin
            r_p1 <= (r_op == rag_pkg::OP_MUL) ? r_an * r_bn : r_an * r_bd;
            r_p2 <= r_bn * r_ad;
        end
        if (r_state == rag_pkg::S_SUM) begin
            unique case (r_op)
                rag_pkg::OP_ADD: r_rn <= (MW+1)'(r_p1) + (MW+1)'(r_p2);
                rag_pkg::OP_SUB: r_rn <= (MW+1)'(r_p1) - (MW+1)'(r_p2);
                default:         r_rn <= (MW+1)'(r_p1);
            endcase
            r_rd  <= (r_op == rag_pkg::OP_DIV) ? r_ad * r_bn : r_ad * r_bd;
            r_err <= (r_ad == '0) || (r_bd == '0)
                     || ((r_op == rag_pkg::OP_DIV) && (r_bn == '0));
        end
        if (r_state == rag_pkg::S_GCD && w_gcd_done) begin
            r_g <= w_gcd_g;
        end
    end

    rag_gcd #(
        .MW (MW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (w_mag_n),
        .i_y     (w_mag_d),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    logic r_launch;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= (r_state == rag_pkg::S_GCD) && w_gcd_done;
        end
    end

    assign w_chain_valid[0] = r_launch;
    assign w_chain_div[0]   = r_g;
    assign w_rem_n[0]       = '0;
    assign w_dvd_n[0]       = w_mag_n;
    assign w_quo_n[0]       = '0;
    assign w_rem_d[0]       = '0;
    assign w_dvd_d[0]       = w_mag_d;
    assign w_quo_d[0]       = '0;

    for (genvar gi = 0; gi < MW; gi++) begin : g_cell
        rag_cell #(
            .MW (MW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_chain_valid[gi]),
            .i_div   (w_chain_div[gi]),
            .i_rem_n (w_rem_n[gi]),
            .i_dvd_n (w_dvd_n[gi]),
            .i_quo_n (w_quo_n[gi]),
            .i_rem_d (w_rem_d[gi]),
            .i_dvd_d (w_dvd_d[gi]),
            .i_quo_d (w_quo_d[gi]),
            .o_valid (w_chain_valid[gi+1]),
            .o_div   (w_chain_div[gi+1]),
            .o_rem_n (w_rem_n[gi+1]),
            .o_dvd_n (w_dvd_n[gi+1]),
            .o_quo_n (w_quo_n[gi+1]),
            .o_rem_d (w_rem_d[gi+1]),
            .o_dvd_d (w_dvd_d[gi+1]),
            .o_quo_d (w_quo_d[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rag_pkg::S_DIV && w_chain_valid[MW]) begin
            r_qn <= w_quo_n[MW];
            r_qd <= w_quo_d[MW];
        end
    end

    // restore the signs of the cross products, then fit to the port widths
    logic signed [MW:0] w_sn, w_sd;
    logic signed [63:0] w_wn, w_wd;
    assign w_sn = r_rn[MW]   ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});
    assign w_sd = r_rd[MW-1] ? -$signed({1'b0, r_qd}) : $signed({1'b0, r_qd});
    assign w_wn = 64'(w_sn);
    assign w_wd = 64'(w_sd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_num    <= r_err ? '0 : w_wn[rag_pkg::NUM_W-1:0];
            r_out_den    <= r_err ? '0 : w_wd[rag_pkg::DEN_W-1:0];
            r_out_status <= r_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result_num = r_out_num;
    assign o_result_den = r_out_den;
    assign o_status     = r_out_status;

endmodule
